// ===== design/tlrb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrb_pkg
// Shared widths, limits and the saturating add for the leaf range builder.
// ----------------------------------------------------------------------------
package tlrb_pkg;

  localparam int unsigned OFF_W         = 10;   // child offset width
  localparam int unsigned QRY_W         = 10;   // query node width
  localparam int unsigned VAL_W         = 11;   // count / start width
  localparam int unsigned MAX_NODES_DEF = 1024;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // result is {overflow, saturated sum}
  function automatic logic [VAL_W:0] sat_add(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
    logic [VAL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[VAL_W]) begin
      sat_add = {1'b1, VAL_MAX};
    end else begin
      sat_add = {1'b0, sum[VAL_W-1:0]};
    end
  endfunction

endpackage

// ===== design/tree_leaf_range_builder.sv =====
// ----------------------------------------------------------------------------
// tree_leaf_range_builder
// Loads a flat decision tree, then derives each node's contiguous leaf span.
// A load beat without last_node set leaves busy low. An invalid query beat
// gets its result strobe from the output registers; a valid one first passes
// through ST_QRY for one RAM read, with busy high. A load with last_node set
// keeps busy high through the clear, parent, count, root and span passes, one
// read port per node RAM. Results cannot be held off.
// Reset clears control state and the tree-ready flag; node RAMs are not reset.
// ----------------------------------------------------------------------------
module tree_leaf_range_builder
  import tlrb_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             command_i,
  input  logic [OFF_W-1:0] child_offset_i,
  input  logic             last_node_i,
  input  logic [QRY_W-1:0] query_node_i,
  output logic             valid_o,
  output logic [VAL_W-1:0] span_start_o,
  output logic [VAL_W-1:0] span_count_o,
  output logic             tree_error_o
);

  localparam int unsigned IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NCNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned AW     = ((NCNT_W > OFF_W) ? NCNT_W : OFF_W) + 2;
  localparam logic [AW-1:0] MAX_A = AW'(MAX_NODES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_QRY, ST_CLR,
    ST_P1_RD, ST_P1_W0, ST_P1_W1,
    ST_P2_RD, ST_P2_W, ST_P2_RU, ST_P2_WU,
    ST_ROOT_RD, ST_ROOT_W,
    ST_P3_RD, ST_P3_CK, ST_P3_W
  } state_e;

  state_e            state_q;
  logic [NCNT_W-1:0] n_q;
  logic              err_q, ready_q;
  logic [IDX_W-1:0]  i_q;
  logic [AW-1:0]     t_q;        // target child index / parent index
  logic [VAL_W-1:0]  val_q;      // carried count or start
  logic [OFF_W-1:0]  d_q;
  logic              valid_q, terr_q;
  logic [VAL_W-1:0]  sstart_q, scount_q;

  // RAM ports
  logic              c_we, p_we, l_we, s_we;
  logic [IDX_W-1:0]  c_wa, p_wa, l_wa, s_wa;
  logic [IDX_W-1:0]  c_ra, p_ra, l_ra, s_ra;
  logic [OFF_W-1:0]  c_wd, c_rd;
  logic [VAL_W-1:0]  p_wd, l_wd, s_wd, p_rd, l_rd, s_rd;

  // datapath
  logic [AW-1:0]     i_a, n_a, q_a, n_eff_a, t_a, up_a, p_a;
  logic [NCNT_W-1:0] n_eff;
  logic              has_ch, q_bad;
  logic [VAL_W:0]    inc_r, up_sum_r, sp_sum_r;
  logic [VAL_W-1:0]  new_i;

  assign i_a     = AW'(i_q);
  assign n_a     = AW'(n_q);
  assign q_a     = AW'(query_node_i);
  assign n_eff   = ready_q ? '0 : n_q;
  assign n_eff_a = AW'(n_eff);
  assign t_a     = i_a + AW'(c_rd);
  assign has_ch  = (c_rd != '0) && ((t_a + AW'(1)) < n_a);
  assign p_a     = AW'(p_rd);
  assign up_a    = (p_a <= i_a) ? (i_a - p_a) : i_a;
  assign inc_r   = sat_add(l_rd, VAL_W'(1));
  assign new_i   = (c_rd == '0) ? inc_r[VAL_W-1:0] : l_rd;
  assign up_sum_r = sat_add(l_rd, val_q);
  assign sp_sum_r = sat_add(val_q, l_rd);
  assign q_bad   = !ready_q || (q_a >= n_a) || (q_a >= MAX_A);

  always_comb begin
    c_we = 1'b0; c_wa = n_eff[IDX_W-1:0]; c_wd = child_offset_i;
    p_we = 1'b0; p_wa = i_q;              p_wd = '0;
    l_we = 1'b0; l_wa = i_q;              l_wd = '0;
    s_we = 1'b0; s_wa = i_q;              s_wd = '0;
    c_ra = i_q;
    p_ra = i_q;
    l_ra = i_q;
    s_ra = i_q;
    case (state_q)
      ST_IDLE: begin
        c_we = start && !command_i && (n_eff_a < MAX_A);
        l_ra = q_a[IDX_W-1:0];
        s_ra = q_a[IDX_W-1:0];
      end
      ST_CLR: begin
        p_we = 1'b1;
        l_we = 1'b1;
        s_we = 1'b1;
      end
      ST_P1_W0: begin
        p_we = has_ch;
        p_wa = t_a[IDX_W-1:0];
        p_wd = VAL_W'(c_rd);
      end
      ST_P1_W1: begin
        p_we = 1'b1;
        p_wa = t_q[IDX_W-1:0];
        p_wd = VAL_W'(d_q) + VAL_W'(1);
      end
      ST_P2_W: begin
        l_we = 1'b1;
        l_wd = new_i;
      end
      ST_P2_RU: begin
        l_ra = t_q[IDX_W-1:0];
      end
      ST_P2_WU: begin
        l_we = 1'b1;
        l_wa = t_q[IDX_W-1:0];
        l_wd = up_sum_r[VAL_W-1:0];
      end
      ST_ROOT_RD: begin
        c_ra = '0;
      end
      ST_ROOT_W: begin
        l_we = (c_rd == '0);
        l_wa = '0;
        l_wd = VAL_W'(1);
      end
      ST_P3_CK: begin
        s_we = has_ch;
        s_wa = t_a[IDX_W-1:0];
        s_wd = s_rd;
        l_ra = t_a[IDX_W-1:0];
      end
      ST_P3_W: begin
        s_we = 1'b1;
        s_wa = t_q[IDX_W-1:0];
        s_wd = sp_sum_r[VAL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= '0;
      err_q    <= 1'b0;
      ready_q  <= 1'b0;
      i_q      <= '0;
      t_q      <= '0;
      val_q    <= '0;
      d_q      <= '0;
      valid_q  <= 1'b0;
      terr_q   <= 1'b0;
      sstart_q <= '0;
      scount_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start && command_i) begin
            if (q_bad) begin
              valid_q  <= 1'b1;
              sstart_q <= '0;
              scount_q <= '0;
              terr_q   <= 1'b1;
            end else begin
              state_q <= ST_QRY;
            end
          end else if (start) begin
            if (ready_q) begin
              err_q   <= 1'b0;
              ready_q <= 1'b0;
            end
            if (n_eff_a < MAX_A) begin
              n_q <= n_eff + NCNT_W'(1);
            end else begin
              n_q   <= n_eff;
              err_q <= 1'b1;
            end
            if (last_node_i) begin
              i_q     <= '0;
              state_q <= ST_CLR;
            end
          end
        end
        ST_QRY: begin
          valid_q  <= 1'b1;
          sstart_q <= s_rd;
          scount_q <= l_rd;
          terr_q   <= err_q;
          state_q  <= ST_IDLE;
        end
        ST_CLR: begin
          if (i_a + AW'(1) == n_a) begin
            i_q     <= '0;
            state_q <= ST_P1_RD;
          end else begin
            i_q <= i_q + IDX_W'(1);
          end
        end
        // pass 1: parent offsets
        ST_P1_RD: state_q <= ST_P1_W0;
        ST_P1_W0: begin
          t_q <= t_a + AW'(1);
          d_q <= c_rd;
          if (has_ch) begin
            state_q <= ST_P1_W1;
          end else begin
            if (c_rd != '0) err_q <= 1'b1;
            if (i_a + AW'(1) == n_a) begin
              i_q     <= IDX_W'(n_a - AW'(1));
              state_q <= (n_a == AW'(1)) ? ST_ROOT_RD : ST_P2_RD;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= ST_P1_RD;
            end
          end
        end
        ST_P1_W1: begin
          if (i_a + AW'(1) == n_a) begin
            i_q     <= IDX_W'(n_a - AW'(1));
            state_q <= (n_a == AW'(1)) ? ST_ROOT_RD : ST_P2_RD;
          end else begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= ST_P1_RD;
          end
        end
        // pass 2: bottom-up leaf counts, node n-1 down to 1
        ST_P2_RD: state_q <= ST_P2_W;
        ST_P2_W: begin
          if (c_rd == '0 && inc_r[VAL_W]) err_q <= 1'b1;
          val_q   <= new_i;
          t_q     <= up_a;
          state_q <= ST_P2_RU;
        end
        ST_P2_RU: state_q <= ST_P2_WU;
        ST_P2_WU: begin
          if (up_sum_r[VAL_W]) err_q <= 1'b1;
          if (i_q == IDX_W'(1)) begin
            state_q <= ST_ROOT_RD;
          end else begin
            i_q     <= i_q - IDX_W'(1);
            state_q <= ST_P2_RD;
          end
        end
        // lone leaf root counts as one
        ST_ROOT_RD: state_q <= ST_ROOT_W;
        ST_ROOT_W: begin
          i_q     <= '0;
          state_q <= ST_P3_RD;
        end
        // pass 3: top-down spans
        ST_P3_RD: state_q <= ST_P3_CK;
        ST_P3_CK: begin
          t_q   <= t_a + AW'(1);
          val_q <= s_rd;
          if (has_ch) begin
            state_q <= ST_P3_W;
          end else if (i_a + AW'(1) == n_a) begin
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= ST_P3_RD;
          end
        end
        ST_P3_W: begin
          if (sp_sum_r[VAL_W]) err_q <= 1'b1;
          if (i_a + AW'(1) == n_a) begin
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= ST_P3_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign span_start_o = sstart_q;
  assign span_count_o = scount_q;
  assign tree_error_o = terr_q;

  tlrb_ram #(.DEPTH(MAX_NODES), .WIDTH(OFF_W), .AW(IDX_W)) u_child (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .raddr_i(c_ra), .rdata_o(c_rd)
  );

  tlrb_ram #(.DEPTH(MAX_NODES), .WIDTH(VAL_W), .AW(IDX_W)) u_parent (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .raddr_i(p_ra), .rdata_o(p_rd)
  );

  tlrb_ram #(.DEPTH(MAX_NODES), .WIDTH(VAL_W), .AW(IDX_W)) u_leaf (
    .clk_i(clk_i), .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
    .raddr_i(l_ra), .rdata_o(l_rd)
  );

  tlrb_ram #(.DEPTH(MAX_NODES), .WIDTH(VAL_W), .AW(IDX_W)) u_span (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .raddr_i(s_ra), .rdata_o(s_rd)
  );

endmodule

// ===== design/tlrb_ram.sv =====
// ----------------------------------------------------------------------------
// tlrb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlrb_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== tb/tlrb_span_checker.sv =====
// ----------------------------------------------------------------------------
// tlrb_span_checker
// Watches the command and result channels of the leaf range builder, keeps
// its own copy of the tree state, works out the span each query must return
// and compares every result strobe against the oldest pending span.
// ----------------------------------------------------------------------------
package tlrb_tb_pkg;
  import tlrb_pkg::*;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } tlrb_cmd_e;

  typedef struct packed {
    logic [VAL_W-1:0] first_leaf;
    logic [VAL_W-1:0] leaf_count;
    logic             bad;
  } leaf_span_t;

endpackage

module tlrb_span_checker
  import tlrb_pkg::*;
  import tlrb_tb_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic             command_i,
  input  logic [OFF_W-1:0] child_offset_i,
  input  logic             last_node_i,
  input  logic [QRY_W-1:0] query_node_i,
  input  logic             valid_i,
  input  logic [VAL_W-1:0] span_start_i,
  input  logic [VAL_W-1:0] span_count_i,
  input  logic             tree_error_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [OFF_W-1:0] node_off   [DEPTH];
  logic [VAL_W-1:0] up_off     [DEPTH];
  logic [VAL_W-1:0] leaf_cnt   [DEPTH];
  logic [VAL_W-1:0] first_leaf [DEPTH];
  int unsigned      n_loaded;
  bit               tree_err;
  bit               spans_ready;
  leaf_span_t       pending_spans[$];
  leaf_span_t       want;

  function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, VAL_MAX}) begin
      tree_err = 1'b1;
      return VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic bit has_kids(input int unsigned i, input int unsigned n);
    return node_off[i] != '0 && i + 32'(node_off[i]) + 1 < n;
  endfunction

  // parent links, bottom-up leaf counts, then top-down span starts
  function automatic void build_spans();
    int unsigned n;
    int unsigned d;
    int unsigned p;
    int unsigned up;
    int unsigned t;
    n = n_loaded;
    for (int unsigned i = 0; i < n; i++) begin
      up_off[i]     = '0;
      leaf_cnt[i]   = '0;
      first_leaf[i] = '0;
    end
    if (n == 0) return;

    for (int unsigned i = 0; i < n; i++) begin
      d = 32'(node_off[i]);
      if (d == 0) continue;
      if (i + d + 1 < n) begin
        up_off[i+d]   = VAL_W'(d);
        up_off[i+d+1] = VAL_W'(d + 1);
      end else begin
        tree_err = 1'b1;
      end
    end

    // a node nobody points at folds its count into itself
    for (int unsigned i = n - 1; i > 0; i--) begin
      p = 32'(up_off[i]);
      if (node_off[i] == '0) leaf_cnt[i] = sat_sum(leaf_cnt[i], VAL_W'(1));
      up = (p <= i) ? i - p : i;
      leaf_cnt[up] = sat_sum(leaf_cnt[up], leaf_cnt[i]);
    end
    if (node_off[0] == '0) leaf_cnt[0] = VAL_W'(1);

    first_leaf[0] = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!has_kids(i, n)) continue;
      t = i + 32'(node_off[i]);
      first_leaf[t]   = first_leaf[i];
      first_leaf[t+1] = sat_sum(first_leaf[t], leaf_cnt[t]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_loaded    = 0;
      tree_err    = 1'b0;
      spans_ready = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        up_off[i]   = '0;
        leaf_cnt[i] = '0;
      end
      pending_spans.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a query beat at this edge cannot answer at this edge
      if (valid_i) begin
        if (pending_spans.size() == 0) begin
          $error("result strobe with no query outstanding");
          fail_count_o++;
        end else begin
          want = pending_spans.pop_front();
          if (span_start_i !== want.first_leaf) begin
            $error("span_start: expected %0d, got %0d", want.first_leaf, span_start_i);
            fail_count_o++;
          end
          if (span_count_i !== want.leaf_count) begin
            $error("span_count: expected %0d, got %0d", want.leaf_count, span_count_i);
            fail_count_o++;
          end
          if (tree_error_i !== want.bad) begin
            $error("tree_error: expected %0d, got %0d", want.bad, tree_error_i);
            fail_count_o++;
          end
        end
      end

      if (start_i && !busy_i) begin
        if (command_i == CMD_LOAD) begin
          if (spans_ready) begin
            n_loaded    = 0;
            tree_err    = 1'b0;
            spans_ready = 1'b0;
          end
          if (n_loaded < DEPTH) begin
            node_off[n_loaded] = child_offset_i;
            n_loaded++;
          end else begin
            tree_err = 1'b1;
          end
          if (last_node_i) begin
            build_spans();
            spans_ready = 1'b1;
          end
        end else begin
          if (!spans_ready || query_node_i >= n_loaded) begin
            want = '{first_leaf: '0, leaf_count: '0, bad: 1'b1};
          end else begin
            want = '{first_leaf: first_leaf[query_node_i],
                     leaf_count: leaf_cnt[query_node_i],
                     bad:        tree_err};
          end
          pending_spans = {pending_spans, want};
        end
      end
      pending_o = pending_spans.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives load and query beats into tree_leaf_range_builder: directed corner
// trees, one tree that overfills the node store, then random trees (mostly
// well formed, some malformed) each followed by span queries, with random
// gaps between beats. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlrb_pkg::*;
  import tlrb_tb_pkg::*;

  localparam int unsigned RAND_BEATS = 390;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             command;
  logic [OFF_W-1:0] child_offset;
  logic             last_node;
  logic [QRY_W-1:0] query_node;
  logic             span_valid;
  logic [VAL_W-1:0] span_start;
  logic [VAL_W-1:0] span_count;
  logic             tree_error;
  int               fail_count;
  int               pending;

  int unsigned      beats;
  bit               idle_on;
  logic [OFF_W-1:0] shape [MAX_NODES_DEF];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tree_leaf_range_builder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command),
    .child_offset_i (child_offset),
    .last_node_i    (last_node),
    .query_node_i   (query_node),
    .valid_o        (span_valid),
    .span_start_o   (span_start),
    .span_count_o   (span_count),
    .tree_error_o   (tree_error)
  );

  tlrb_span_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command),
    .child_offset_i (child_offset),
    .last_node_i    (last_node),
    .query_node_i   (query_node),
    .valid_i        (span_valid),
    .span_start_i   (span_start),
    .span_count_i   (span_count),
    .tree_error_i   (tree_error),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // one beat: optional idle gap, then hold start until the block takes it
  task automatic send_beat(input tlrb_cmd_e cmd, input logic [OFF_W-1:0] off,
                           input logic last, input logic [QRY_W-1:0] qn);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    command      <= cmd;
    child_offset <= off;
    last_node    <= last;
    query_node   <= qn;
    do @(posedge clk_i); while (busy);
    beats++;
    if (beats % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic load_node(input logic [OFF_W-1:0] off, input logic last);
    send_beat(CMD_LOAD, off, last, QRY_W'($urandom_range(0, 1023)));
  endtask

  task automatic ask_span(input logic [QRY_W-1:0] qn);
    send_beat(CMD_QUERY, OFF_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), qn);
  endtask

  // breadth-first layout: children of a node sit side by side further on
  function automatic int unsigned grow_tree(input int unsigned limit,
                                            input int unsigned pct);
    int unsigned next_free;
    next_free = 1;
    for (int unsigned i = 0; i < next_free; i++) begin
      if (next_free + 2 <= limit && $urandom_range(0, 99) < pct) begin
        shape[i] = OFF_W'(next_free - i);
        next_free += 2;
      end else begin
        shape[i] = '0;
      end
    end
    return next_free;
  endfunction

  // some queries land mid-load, before the new tree has spans
  task automatic load_shape(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      load_node(shape[i], i == n - 1);
      if (i != n - 1 && $urandom_range(0, 15) == 0) ask_span(QRY_W'($urandom_range(0, 1023)));
    end
  endtask

  task automatic ask_spans(input int unsigned n, input int unsigned cnt);
    int unsigned r;
    for (int unsigned k = 0; k < cnt; k++) begin
      r = $urandom_range(0, 9);
      if (r < 8) ask_span(QRY_W'($urandom_range(0, n - 1)));
      else if (r == 8 && n < 1024) ask_span(QRY_W'($urandom_range(n, 1023)));
      else ask_span(QRY_W'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned kind;
    int unsigned rand_base;

    rst_ni       = 1'b0;
    start        = 1'b0;
    command      = CMD_LOAD;
    child_offset = '0;
    last_node    = 1'b0;
    query_node   = '0;
    beats        = 0;
    idle_on      = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no tree yet
    ask_span('0);
    ask_span(QRY_W'(1023));
    // lone leaf root, then a query of it and one past the end
    load_node('0, 1'b1);
    ask_span('0);
    ask_span(QRY_W'(1));
    // three-node tree, with a query while it is still loading
    load_node(OFF_W'(1), 1'b0);
    ask_span('0);
    load_node('0, 1'b0);
    load_node('0, 1'b1);
    ask_span('0);
    ask_span(QRY_W'(1));
    ask_span(QRY_W'(2));
    // child far beyond the loaded nodes
    load_node(OFF_W'(1023), 1'b1);
    ask_span('0);
    // node 1 has no parent
    load_node(OFF_W'(2), 1'b0);
    load_node('0, 1'b0);
    load_node('0, 1'b0);
    load_node('0, 1'b1);
    ask_span(QRY_W'(1));
    ask_span(QRY_W'(3));
    // last_node set on a query beat does nothing
    send_beat(CMD_QUERY, OFF_W'(1023), 1'b1, QRY_W'(2));

    // fill the store, then one more node that gets dropped but ends the tree
    n = grow_tree(MAX_NODES_DEF - 1, 100);
    for (int unsigned i = n; i < MAX_NODES_DEF; i++) shape[i] = '0;
    for (int unsigned i = 0; i < MAX_NODES_DEF; i++) load_node(shape[i], 1'b0);
    load_node(OFF_W'($urandom_range(0, 1023)), 1'b1);
    ask_span('0);
    ask_span(QRY_W'(1023));
    ask_spans(MAX_NODES_DEF, 10);

    rand_base = beats;
    while (beats - rand_base < RAND_BEATS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        n = grow_tree(($urandom_range(0, 11) == 0) ? $urandom_range(41, 300)
                                                   : $urandom_range(1, 40),
                      $urandom_range(40, 90));
      end else if (kind <= 8) begin
        n = $urandom_range(1, 30);
        for (int unsigned i = 0; i < n; i++)
          shape[i] = $urandom_range(0, 1) ? '0 : OFF_W'($urandom_range(1, 4));
      end else begin
        n = $urandom_range(1, 20);
        for (int unsigned i = 0; i < n; i++)
          shape[i] = ($urandom_range(0, 2) == 0) ? '0 : OFF_W'($urandom_range(0, 1023));
      end
      load_shape(n);
      ask_spans(n, $urandom_range(1, (n < 28) ? n + 3 : 30));
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== tree_leaf_range_builder.f =====
design/tlrb_pkg.sv
design/tlrb_ram.sv
design/tree_leaf_range_builder.sv
tb/tlrb_span_checker.sv
tb/tb_top.sv
